// File: hw/rtl/fcs_pkg.sv
// Shared constants and types for the filled circle span generator.
package fcs_pkg;

  // Configuration port layout.
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS        = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ASPECT_FACTOR = 3'd3;

  // Register widths and reset values.
  localparam int RADIUS_BITS = 5;
  localparam int DIM_BITS    = 12;
  localparam int ASPECT_BITS = 12;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET        = 5'd5;
  localparam logic [DIM_BITS-1:0]    SCREEN_WIDTH_RESET  = 12'd120;
  localparam logic [DIM_BITS-1:0]    SCREEN_HEIGHT_RESET = 12'd30;
  localparam logic [ASPECT_BITS-1:0] ASPECT_RESET        = 12'd497;

  // Screen dimensions saturate at this value.
  localparam logic [DIM_BITS-1:0] SCREEN_LIMIT = 12'd2048;

  // Fraction bits of the root and of the aspect factor.
  localparam int FRAC_BITS = 8;

  // Output span field widths.
  localparam int START_BITS = 11;
  localparam int END_BITS   = 12;

  // Status of the iterative square root unit.
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

// File: hw/rtl/fcs_req_if.sv
// Draw request channel: circle centre words with valid and ready.
interface fcs_req_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;

  modport source (output valid, output center_x, output center_y, input ready);
  modport sink   (input valid, input center_x, input center_y, output ready);
endinterface

// File: hw/rtl/fcs_span_if.sv
// Span result channel: one row span word per handshake.
interface fcs_span_if #(
  parameter int COORD_BITS = 12
);
  logic                                 valid;
  logic                                 ready;
  logic signed [COORD_BITS:0]           row;
  logic [fcs_pkg::START_BITS-1:0]       span_start;
  logic [fcs_pkg::END_BITS-1:0]         span_end;
  logic                                 visible;
  logic                                 last;

  modport source (output valid, output row, output span_start, output span_end,
                  output visible, output last, input ready);
  modport sink   (input valid, input row, input span_start, input span_end,
                  input visible, input last, output ready);
endinterface

// File: hw/rtl/fcs_sqrt.sv
// Iterative integer square root, one result bit per cycle.
module fcs_sqrt #(
  parameter int ROOT_BITS = 13
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [2*ROOT_BITS-1:0]   operand,
  output logic [ROOT_BITS-1:0]     root,
  output fcs_pkg::sqrt_stat_t      stat
);

  localparam int REM_BITS = ROOT_BITS + 2;
  localparam int CNT_BITS = $clog2(ROOT_BITS + 1);

  logic [2*ROOT_BITS-1:0] op;
  logic [REM_BITS-1:0]    rem;
  logic [CNT_BITS-1:0]    cnt;
  logic                   busy;
  logic                   done;

  logic [REM_BITS+1:0]    rem_sh;
  logic [REM_BITS+1:0]    trial;
  logic                   take;

  // Bring down the next two operand bits and try a one in the next root bit.
  assign rem_sh = {rem, op[2*ROOT_BITS-1 -: 2]};
  assign trial  = {{(REM_BITS-ROOT_BITS){1'b0}}, root, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        op   <= operand;
        rem  <= '0;
        root <= '0;
        cnt  <= CNT_BITS'(ROOT_BITS);
        busy <= 1'b1;
      end else if (busy) begin
        op <= {op[2*ROOT_BITS-3:0], 2'b00};
        if (take) begin
          rem  <= REM_BITS'(rem_sh - trial);
          root <= {root[ROOT_BITS-2:0], 1'b1};
        end else begin
          rem  <= REM_BITS'(rem_sh);
          root <= {root[ROOT_BITS-2:0], 1'b0};
        end
        cnt <= cnt - CNT_BITS'(1);
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: hw/rtl/filled_circle_span_generator.sv
// Top level: sequencer and span datapath of the filled circle span generator.
//
//   Channel  Role    Word
//   req      sink    center_x, center_y (signed, COORD_BITS each)
//   span     source  row, span_start, span_end, visible, last
//   cfg_*    write   cfg_index selects radius, width, height or aspect
//
// Each row passes through the prep, wait, multiply and span steps, the wait lasting
// while the bit-per-cycle square root unit runs. A request of radius r yields 2r+1
// rows, and no new request is taken until the last of its rows is loaded.
// Reset is synchronous and loads the register defaults. A stalled span word
// holds the next row in its final step until the output register frees up.
module filled_circle_span_generator #(
  parameter int MAX_RADIUS = 31,
  parameter int COORD_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [fcs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [fcs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  fcs_req_if.sink                            req,
  fcs_span_if.source                         span
);

  localparam int RB        = (MAX_RADIUS < 2) ? 1 : $clog2(MAX_RADIUS + 1);
  localparam int ROOT_BITS = RB + fcs_pkg::FRAC_BITS;
  localparam int HQB       = ROOT_BITS - 3;
  localparam int SW0       = (COORD_BITS > HQB) ? COORD_BITS : HQB;
  localparam int SW        = ((SW0 > fcs_pkg::DIM_BITS) ? SW0 : fcs_pkg::DIM_BITS) + 2;
  localparam int MUL_BITS  = ROOT_BITS + fcs_pkg::ASPECT_BITS;
  localparam int HALF_BITS = MUL_BITS - fcs_pkg::FRAC_BITS;

  localparam logic [RB-1:0] RMAX = RB'(MAX_RADIUS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SPAN = 3'd4;

  // Configuration registers.
  logic [fcs_pkg::RADIUS_BITS-1:0] radius;
  logic [fcs_pkg::DIM_BITS-1:0]    screen_width;
  logic [fcs_pkg::DIM_BITS-1:0]    screen_height;
  logic [fcs_pkg::ASPECT_BITS-1:0] aspect_factor;

  // Sequencer and request state.
  logic [2:0]                   state;
  logic [RB-1:0]                r_lat;
  logic signed [RB:0]           row_offset;
  logic signed [COORD_BITS-1:0] latched_center_x;
  logic signed [COORD_BITS-1:0] latched_center_y;
  logic [HALF_BITS-1:0]         half;

  // Output register.
  logic                           out_valid;
  logic signed [COORD_BITS:0]     out_row;
  logic [fcs_pkg::START_BITS-1:0] out_start;
  logic [fcs_pkg::END_BITS-1:0]   out_end;
  logic                           out_vis;
  logic                           out_last;

  logic [RB-1:0]              r_eff;
  logic [fcs_pkg::DIM_BITS-1:0] w_eff;
  logic [fcs_pkg::DIM_BITS-1:0] h_eff;
  logic signed [RB:0]         r_s;
  logic signed [RB+1:0]       diff_w;
  logic signed [RB+1:0]       sum_w;
  logic [2*RB+1:0]            n_full;
  logic [2*ROOT_BITS-1:0]     sq_operand;
  logic [ROOT_BITS-1:0]       root;
  fcs_pkg::sqrt_stat_t        sq_stat;
  logic                       sq_start;
  logic [MUL_BITS-1:0]        mul_full;
  logic [HALF_BITS:0]         hq_full;
  logic [HQB-1:0]             hq;
  logic signed [COORD_BITS:0] row_w;
  logic signed [SW-1:0]       cx_s;
  logic signed [SW-1:0]       hq_s;
  logic signed [SW-1:0]       st;
  logic signed [SW-1:0]       en;
  logic signed [SW-1:0]       st_c;
  logic signed [SW-1:0]       en_c;
  logic signed [SW-1:0]       w_s;
  logic signed [SW-1:0]       h_s;
  logic signed [SW-1:0]       row_s;
  logic                       vis;
  logic                       is_last;
  logic                       out_free;
  logic                       load;

  // Saturated radius and screen dimensions.
  assign r_eff = (int'(radius) > MAX_RADIUS) ? RMAX : radius[RB-1:0];
  assign w_eff = (screen_width > fcs_pkg::SCREEN_LIMIT) ? fcs_pkg::SCREEN_LIMIT : screen_width;
  assign h_eff = (screen_height > fcs_pkg::SCREEN_LIMIT) ? fcs_pkg::SCREEN_LIMIT : screen_height;

  // Chord square r*r - d*d as (r - d) * (r + d), scaled for 8 root fraction bits.
  assign r_s        = {1'b0, r_lat};
  assign diff_w     = {r_s[RB], r_s} - {row_offset[RB], row_offset};
  assign sum_w      = {r_s[RB], r_s} + {row_offset[RB], row_offset};
  assign n_full     = (2*RB+2)'(diff_w[RB:0]) * (2*RB+2)'(sum_w[RB:0]);
  assign sq_operand = {n_full[2*RB-1:0], {(2*fcs_pkg::FRAC_BITS){1'b0}}};
  assign sq_start   = (state == S_PREP);
  assign is_last    = (row_offset == -r_s);

  fcs_sqrt #(
    .ROOT_BITS (ROOT_BITS)
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (sq_operand),
    .root    (root),
    .stat    (sq_stat)
  );

  // Half length in Q.8, then its ceiling in whole columns.
  assign mul_full = MUL_BITS'(root) * MUL_BITS'(aspect_factor);
  assign hq_full  = {1'b0, half} + (HALF_BITS+1)'(255);
  assign hq       = hq_full[fcs_pkg::FRAC_BITS +: HQB];

  // Span bounds and clipping.
  assign cx_s  = {{(SW-COORD_BITS){latched_center_x[COORD_BITS-1]}}, latched_center_x};
  assign hq_s  = {{(SW-HQB){1'b0}}, hq};
  assign st    = cx_s - hq_s;
  assign en    = cx_s + hq_s;
  assign w_s   = {{(SW-fcs_pkg::DIM_BITS){1'b0}}, w_eff};
  assign h_s   = {{(SW-fcs_pkg::DIM_BITS){1'b0}}, h_eff};
  assign row_w = {latched_center_y[COORD_BITS-1], latched_center_y}
               + {{(COORD_BITS-RB){row_offset[RB]}}, row_offset};
  assign row_s = {{(SW-COORD_BITS-1){row_w[COORD_BITS]}}, row_w};
  assign st_c  = st[SW-1] ? '0 : st;
  assign en_c  = (en > w_s) ? w_s : en;
  assign vis   = !row_s[SW-1] && (row_s < h_s) && (st_c < en_c);

  assign out_free = !out_valid || span.ready;
  assign load     = (state == S_SPAN) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius           <= fcs_pkg::RADIUS_RESET;
      screen_width     <= fcs_pkg::SCREEN_WIDTH_RESET;
      screen_height    <= fcs_pkg::SCREEN_HEIGHT_RESET;
      aspect_factor    <= fcs_pkg::ASPECT_RESET;
      state            <= S_IDLE;
      row_offset       <= '0;
      latched_center_x <= '0;
      latched_center_y <= '0;
      out_valid        <= 1'b0;
    end else begin
      // Register writes; unknown indexes are dropped.
      if (cfg_we) begin
        unique case (cfg_index)
          fcs_pkg::CFG_RADIUS:        radius        <= cfg_data[fcs_pkg::RADIUS_BITS-1:0];
          fcs_pkg::CFG_SCREEN_WIDTH:  screen_width  <= cfg_data[fcs_pkg::DIM_BITS-1:0];
          fcs_pkg::CFG_SCREEN_HEIGHT: screen_height <= cfg_data[fcs_pkg::DIM_BITS-1:0];
          fcs_pkg::CFG_ASPECT_FACTOR: aspect_factor <= cfg_data[fcs_pkg::ASPECT_BITS-1:0];
          default: ;
        endcase
      end

      // A taken word empties the output register unless a new one moves in.
      if (span.valid && span.ready && !load) begin
        out_valid <= 1'b0;
      end

      // Row sequencer.
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            latched_center_x <= req.center_x;
            latched_center_y <= req.center_y;
            r_lat            <= r_eff;
            row_offset       <= {1'b0, r_eff};
            state            <= S_PREP;
          end
        end
        S_PREP: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (sq_stat.done) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          half  <= mul_full[MUL_BITS-1:fcs_pkg::FRAC_BITS];
          state <= S_SPAN;
        end
        S_SPAN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_row   <= row_w;
            out_start <= vis ? st_c[fcs_pkg::START_BITS-1:0] : '0;
            out_end   <= vis ? en_c[fcs_pkg::END_BITS-1:0] : '0;
            out_vis   <= vis;
            out_last  <= is_last;
            if (is_last) begin
              row_offset <= '0;
              state      <= S_IDLE;
            end else begin
              row_offset <= row_offset - (RB+1)'(1);
              state      <= S_PREP;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign span.valid      = out_valid;
  assign span.row        = out_row;
  assign span.span_start = out_start;
  assign span.span_end   = out_end;
  assign span.visible    = out_vis;
  assign span.last       = out_last;

`ifndef SYNTHESIS
  // The root unit finishes only while the sequencer waits for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sq_stat.done |-> (state == S_WAIT))
    else $error("square root finished outside the wait step");

  // While waiting, the root unit is either working or just finished.
  a_wait_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAIT) |-> (sq_stat.busy || sq_stat.done))
    else $error("waiting on an idle square root unit");

  // A new span word never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (span.valid && !span.ready && state == S_SPAN) |=> span.valid && $stable(span.row))
    else $error("pending span word overwritten");

  // The row offset stays within the latched radius during a request.
  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> ((row_offset <= r_s) && (row_offset >= -r_s)))
    else $error("row offset outside the radius");
`endif

endmodule

// File: verif/filled_circle_span_generator_tb.sv
// Self-checking testbench for the filled circle span generator.
module filled_circle_span_generator_tb;

  localparam int COORD_BITS = 12;
  localparam int MAX_RADIUS = 31;

  // Indexes above the last register are decoded as no-ops by the block.
  localparam logic [fcs_pkg::CFG_IDX_BITS-1:0] CFG_FIRST_SPARE = 3'd4;

  // One span word as the block should present it.
  typedef struct packed {
    logic signed [COORD_BITS:0]         row;
    logic [fcs_pkg::START_BITS-1:0]     span_start;
    logic [fcs_pkg::END_BITS-1:0]       span_end;
    logic                               visible;
    logic                               last;
  } span_word_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              cfg_we;
  logic [fcs_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [fcs_pkg::CFG_DATA_BITS-1:0] cfg_data;

  fcs_req_if  #(.COORD_BITS(COORD_BITS)) req ();
  fcs_span_if #(.COORD_BITS(COORD_BITS)) span ();

  filled_circle_span_generator #(
    .MAX_RADIUS(MAX_RADIUS),
    .COORD_BITS(COORD_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req),
    .span     (span)
  );

  // Shadow copy of the geometry registers.
  logic [fcs_pkg::RADIUS_BITS-1:0] radius_reg = fcs_pkg::RADIUS_RESET;
  logic [fcs_pkg::DIM_BITS-1:0]    width_reg  = fcs_pkg::SCREEN_WIDTH_RESET;
  logic [fcs_pkg::DIM_BITS-1:0]    height_reg = fcs_pkg::SCREEN_HEIGHT_RESET;
  logic [fcs_pkg::ASPECT_BITS-1:0] aspect_reg = fcs_pkg::ASPECT_RESET;

  span_word_t  pending_spans[$];
  int unsigned mismatches = 0;

  // Odds of an idle burst per opportunity; zero turns idling off.
  int gap_odds   = 4;
  int stall_odds = 4;
  int stall_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Truncated square root, built one result bit at a time from the top.
  function automatic longint chord_root(input longint radicand);
    longint root;
    longint trial;
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= radicand) root = trial;
    end
    return root;
  endfunction

  // Queue every row span that one circle request should produce.
  task automatic predict_spans(input logic signed [COORD_BITS-1:0] cx,
                               input logic signed [COORD_BITS-1:0] cy);
    int         r;
    int         w;
    int         h;
    longint     root;
    longint     half;
    longint     lo;
    longint     hi;
    longint     row;
    span_word_t s;
    r = (int'(radius_reg) > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
    w = int'((width_reg > fcs_pkg::SCREEN_LIMIT) ? fcs_pkg::SCREEN_LIMIT : width_reg);
    h = int'((height_reg > fcs_pkg::SCREEN_LIMIT) ? fcs_pkg::SCREEN_LIMIT : height_reg);
    for (int d = r; d >= -r; d--) begin
      root = chord_root(longint'(r * r - d * d) << (2 * fcs_pkg::FRAC_BITS));
      half = (root * longint'(aspect_reg)) >> fcs_pkg::FRAC_BITS;
      row  = longint'(cy) + d;
      lo   = ((longint'(cx) <<< fcs_pkg::FRAC_BITS) - half) >>> fcs_pkg::FRAC_BITS;
      hi   = ((longint'(cx) <<< fcs_pkg::FRAC_BITS) + half + (1 << fcs_pkg::FRAC_BITS) - 1)
             >>> fcs_pkg::FRAC_BITS;
      if (lo < 0) lo = 0;
      if (hi > w) hi = w;
      s.visible = (row >= 0) && (row < h) && (lo < hi);
      if (!s.visible) begin
        lo = 0;
        hi = 0;
      end
      s.row        = row[COORD_BITS:0];
      s.span_start = lo[fcs_pkg::START_BITS-1:0];
      s.span_end   = hi[fcs_pkg::END_BITS-1:0];
      s.last       = (d == -r);
      pending_spans.push_back(s);
    end
  endtask

  // Compare each accepted span word with the oldest prediction.
  always @(posedge clk) begin : span_checker
    span_word_t want;
    if (!rst && span.valid && span.ready) begin
      if (pending_spans.size() == 0) begin
        $error("unexpected span word: row %0d start %0d end %0d",
               span.row, span.span_start, span.span_end);
        mismatches++;
      end else begin
        want = pending_spans.pop_front();
        if (span.row !== want.row) begin
          $error("row: expected %0d, got %0d", want.row, span.row);
          mismatches++;
        end
        if (span.span_start !== want.span_start) begin
          $error("span_start: expected %0d, got %0d", want.span_start, span.span_start);
          mismatches++;
        end
        if (span.span_end !== want.span_end) begin
          $error("span_end: expected %0d, got %0d", want.span_end, span.span_end);
          mismatches++;
        end
        if (span.visible !== want.visible) begin
          $error("visible: expected %0b, got %0b", want.visible, span.visible);
          mismatches++;
        end
        if (span.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, span.last);
          mismatches++;
        end
      end
    end
  end

  // Back-pressure on the span channel in bursts of random length.
  always @(posedge clk) begin : span_backpressure
    if (rst || stall_odds == 0) begin
      stall_left <= 0;
      span.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      span.ready <= 1'b0;
    end else if ($urandom_range(0, stall_odds - 1) == 0) begin
      stall_left <= $urandom_range(0, 10);
      span.ready <= 1'b0;
    end else begin
      span.ready <= 1'b1;
    end
  end

  // Offer one request word, with an optional idle burst ahead of it.
  task automatic send_request(input logic signed [COORD_BITS-1:0] cx,
                              input logic signed [COORD_BITS-1:0] cy);
    int gap;
    gap = 0;
    if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) gap = $urandom_range(1, 11);
    if (gap != 0) begin
      req.valid    <= 1'b0;
      req.center_x <= COORD_BITS'($urandom);
      req.center_y <= COORD_BITS'($urandom);
      repeat (gap) @(posedge clk);
    end
    req.valid    <= 1'b1;
    req.center_x <= cx;
    req.center_y <= cy;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_spans(cx, cy);
  endtask

  // Stop offering requests and wait for every predicted span to arrive.
  task automatic settle();
    req.valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fcs_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [fcs_pkg::CFG_DATA_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      fcs_pkg::CFG_RADIUS:        radius_reg = value[fcs_pkg::RADIUS_BITS-1:0];
      fcs_pkg::CFG_SCREEN_WIDTH:  width_reg  = value[fcs_pkg::DIM_BITS-1:0];
      fcs_pkg::CFG_SCREEN_HEIGHT: height_reg = value[fcs_pkg::DIM_BITS-1:0];
      fcs_pkg::CFG_ASPECT_FACTOR: aspect_reg = value[fcs_pkg::ASPECT_BITS-1:0];
      default: ;
    endcase
  endtask

  // Reprogram all four registers while idle; a spare index write must do nothing.
  task automatic load_geometry(input logic [fcs_pkg::RADIUS_BITS-1:0] rad,
                               input logic [fcs_pkg::DIM_BITS-1:0]    wid,
                               input logic [fcs_pkg::DIM_BITS-1:0]    hgt,
                               input logic [fcs_pkg::ASPECT_BITS-1:0] asp);
    logic [fcs_pkg::CFG_DATA_BITS-fcs_pkg::RADIUS_BITS-1:0] junk;
    settle();
    junk = (fcs_pkg::CFG_DATA_BITS-fcs_pkg::RADIUS_BITS)'($urandom);
    write_reg(fcs_pkg::CFG_RADIUS, {junk, rad});
    write_reg(fcs_pkg::CFG_SCREEN_WIDTH, wid);
    write_reg(fcs_pkg::CFG_SCREEN_HEIGHT, hgt);
    write_reg(fcs_pkg::CFG_ASPECT_FACTOR, asp);
    write_reg(CFG_FIRST_SPARE + fcs_pkg::CFG_IDX_BITS'($urandom_range(0, 3)),
              fcs_pkg::CFG_DATA_BITS'($urandom));
    cfg_we <= 1'b0;
  endtask

  // A coordinate around a screen extent, clamped to the signed field.
  function automatic logic signed [COORD_BITS-1:0] near_coord(input int extent,
                                                              input int margin);
    int v;
    v = int'($urandom_range(0, extent + 2 * margin));
    v = v - margin;
    if (v < -2048) v = -2048;
    if (v > 2047) v = 2047;
    return v[COORD_BITS-1:0];
  endfunction

  task automatic test_default_geometry();
    send_request(12'sd60, 12'sd15);
    send_request(12'sd0, 12'sd0);
    send_request(-12'sd2048, -12'sd2048);
    send_request(12'sd2047, 12'sd2047);
    send_request(12'sd119, 12'sd29);
    send_request(-12'sd3, 12'sd2);
  endtask

  // A zero radius gives a single empty span.
  task automatic test_zero_radius();
    load_geometry(5'd0, 12'd120, 12'd30, 12'd497);
    send_request(12'sd10, 12'sd10);
    send_request(12'sd0, 12'sd0);
  endtask

  // Largest radius and stretch, so spans run into both screen edges.
  task automatic test_full_radius();
    load_geometry(5'd31, 12'd2048, 12'd2048, 12'd4095);
    send_request(12'sd1024, 12'sd1024);
    send_request(-12'sd2048, 12'sd31);
    send_request(12'sd2047, -12'sd31);
  endtask

  // Oversized, zero and one-cell screens.
  task automatic test_screen_limits();
    load_geometry(5'd7, 12'd4095, 12'd4095, 12'd497);
    send_request(12'sd2047, 12'sd2047);
    send_request(12'sd2040, 12'sd2044);
    load_geometry(5'd7, 12'd0, 12'd0, 12'd497);
    send_request(12'sd5, 12'sd5);
    load_geometry(5'd3, 12'd1, 12'd1, 12'd256);
    send_request(12'sd0, 12'sd0);
    send_request(12'sd0, 12'sd3);
  endtask

  // No stretch at all, then the smallest nonzero stretch.
  task automatic test_flat_aspect();
    load_geometry(5'd9, 12'd120, 12'd30, 12'd0);
    send_request(12'sd50, 12'sd10);
    load_geometry(5'd4, 12'd120, 12'd30, 12'd1);
    send_request(12'sd50, 12'sd10);
  endtask

  // Random geometry per frame, with circles mostly placed around the screen.
  // With calm set, both channels run without idling.
  task automatic test_random_frames(input int frames, input int per_frame, input bit calm);
    logic [fcs_pkg::RADIUS_BITS-1:0] rad;
    logic [fcs_pkg::DIM_BITS-1:0]    wid;
    logic [fcs_pkg::DIM_BITS-1:0]    hgt;
    logic [fcs_pkg::ASPECT_BITS-1:0] asp;
    for (int f = 0; f < frames; f++) begin
      case ($urandom_range(0, 7))
        0:       rad = 5'd31;
        1:       rad = fcs_pkg::RADIUS_BITS'($urandom);
        default: rad = fcs_pkg::RADIUS_BITS'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 7))
        0:       wid = 12'd0;
        1:       wid = fcs_pkg::DIM_BITS'($urandom);
        2:       wid = 12'd2048;
        default: wid = fcs_pkg::DIM_BITS'($urandom_range(1, 300));
      endcase
      case ($urandom_range(0, 7))
        0:       hgt = 12'd0;
        1:       hgt = fcs_pkg::DIM_BITS'($urandom);
        2:       hgt = 12'd2048;
        default: hgt = fcs_pkg::DIM_BITS'($urandom_range(1, 100));
      endcase
      case ($urandom_range(0, 5))
        0:       asp = fcs_pkg::ASPECT_BITS'($urandom);
        1:       asp = 12'd4095;
        2:       asp = 12'd0;
        default: asp = fcs_pkg::ASPECT_BITS'($urandom_range(200, 800));
      endcase
      load_geometry(rad, wid, hgt, asp);
      gap_odds   = (calm || f % 3 == 2) ? 0 : $urandom_range(2, 6);
      stall_odds = (calm || f % 3 == 2) ? 0 : $urandom_range(2, 6);
      for (int i = 0; i < per_frame; i++) begin
        if ($urandom_range(0, 6) == 0)
          send_request(COORD_BITS'($urandom), COORD_BITS'($urandom));
        else
          send_request(near_coord(int'(wid), 2 * rad + 4), near_coord(int'(hgt), rad + 2));
      end
    end
  endtask

  initial begin
    req.valid    <= 1'b0;
    req.center_x <= '0;
    req.center_y <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= fcs_pkg::CFG_RADIUS;
    cfg_data     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_geometry();
    test_zero_radius();
    test_full_radius();
    test_screen_limits();
    test_flat_aspect();
    test_random_frames(10, 20, 1'b0);

    // Closing stretch at full rate on both sides.
    settle();
    gap_odds   = 0;
    stall_odds = 0;
    test_random_frames(1, 20, 1'b1);

    settle();
    repeat (1100) @(posedge clk);
    if (mismatches == 0) begin
      $display("filled_circle_span_generator_tb: clean");
    end else begin
      $display("filled_circle_span_generator_tb: errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #10000000;
    $display("filled_circle_span_generator_tb: errors");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/fcs_pkg.sv
hw/rtl/fcs_req_if.sv
hw/rtl/fcs_span_if.sv
hw/rtl/fcs_sqrt.sv
hw/rtl/filled_circle_span_generator.sv
verif/filled_circle_span_generator_tb.sv
